[design/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation pipeline.
`default_nettype none
package mexp_pkg;
  typedef logic [29:0] residue_t;
  typedef logic [30:0] expo_t;

  localparam logic [29:0] PRIME     = 30'd1000000007;
  localparam logic [31:0] PRIME_X1  = 32'd1000000007;
  localparam logic [31:0] PRIME_X2  = 32'd2000000014;
  // floor(2^60 / PRIME), Barrett reciprocal
  localparam logic [30:0] BARRETT_M = 31'd1152921496;
  localparam int unsigned MUL_LAT   = 4;
endpackage
`default_nettype wire

[design/mexp_mulmod.sv]
// Four-stage pipelined modular multiplier with Barrett reduction.
`default_nettype none
module mexp_mulmod (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire mexp_pkg::residue_t a,
  input  wire mexp_pkg::residue_t b,
  output mexp_pkg::residue_t      prod_mod
);
  logic [59:0] prod_r;
  logic [61:0] q2_r;
  logic [31:0] xlo1_r;
  logic [31:0] qp_r;
  logic [31:0] xlo2_r;
  mexp_pkg::residue_t res_r;

  logic [59:0] prod_nxt;
  logic [61:0] q2_nxt;
  logic [31:0] qp_nxt;
  logic [31:0] diff;
  mexp_pkg::residue_t res_nxt;

  assign prod_nxt = {30'd0, a} * {30'd0, b};
  assign q2_nxt   = {31'd0, prod_r[59:29]} * {31'd0, mexp_pkg::BARRETT_M};
  assign qp_nxt   = 32'(q2_r[61:31]) * mexp_pkg::PRIME_X1;
  assign diff     = xlo2_r - qp_r;

  // estimate is short by at most two multiples
  always_comb begin
    if (diff >= mexp_pkg::PRIME_X2) begin
      res_nxt = 30'(diff - mexp_pkg::PRIME_X2);
    end else if (diff >= mexp_pkg::PRIME_X1) begin
      res_nxt = 30'(diff - mexp_pkg::PRIME_X1);
    end else begin
      res_nxt = diff[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      q2_r   <= q2_nxt;
      xlo1_r <= prod_r[31:0];
      qp_r   <= qp_nxt;
      xlo2_r <= xlo1_r;
      res_r  <= res_nxt;
    end
  end

  assign prod_mod = res_r;
endmodule
`default_nettype wire

[design/mexp_bit_stage.sv]
// One exponent bit: conditional multiply and square, with sideband delay.
`default_nettype none
module mexp_bit_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               valid_in,
  input  wire mexp_pkg::residue_t acc_in,
  input  wire mexp_pkg::residue_t pow_in,
  input  wire mexp_pkg::expo_t    exp_in,
  output logic                    valid_out,
  output mexp_pkg::residue_t      acc_out,
  output mexp_pkg::residue_t      pow_out,
  output mexp_pkg::expo_t         exp_out
);
  localparam int unsigned LAT = mexp_pkg::MUL_LAT;

  logic [LAT-1:0]  vld_r;
  mexp_pkg::expo_t exp_r [0:LAT-1];
  mexp_pkg::residue_t mul_b;

  assign mul_b = exp_in[0] ? pow_in : 30'd1;

  mexp_mulmod u_acc (.clk(clk), .en(en), .a(acc_in), .b(mul_b), .prod_mod(acc_out));
  mexp_mulmod u_sq  (.clk(clk), .en(en), .a(pow_in), .b(pow_in), .prod_mod(pow_out));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      exp_r[0] <= {1'b0, exp_in[30:1]};
      for (int i = 1; i < LAT; i++) begin
        exp_r[i] <= exp_r[i-1];
      end
    end
  end

  assign valid_out = vld_r[LAT-1];
  assign exp_out   = exp_r[LAT-1];
endmodule
`default_nettype wire

[design/modular_exponentiation.sv]
// Top level: fully pipelined base^exponent mod 1000000007.
// One word enters per cycle when the pipe is not stalled. An input stage
// folds the base below the prime, then each exponent bit owns four stages
// (multiply, Barrett quotient, quotient times prime, subtract and correct)
// running the accumulator multiply and the power square side by side.
// Exponent bits at or above EXP_BITS are ignored. A stalled output freezes
// the whole pipe; in_ready drops only while a finished word waits and
// out_ready is low.
`default_nettype none
module modular_exponentiation #(
  parameter int unsigned EXP_BITS = 31
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [30:0] in_base_value,
  input  wire logic [30:0] in_exponent_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [29:0]      out_power_result
);
  localparam int unsigned SCAN = (EXP_BITS < 31) ? EXP_BITS : 31;
  localparam logic [30:0] EXP_MASK = 31'((64'd1 << SCAN) - 64'd1);

  logic                en;
  logic                vld_c [0:SCAN];
  mexp_pkg::residue_t  acc_c [0:SCAN];
  mexp_pkg::residue_t  pow_c [0:SCAN];
  mexp_pkg::expo_t     exp_c [0:SCAN];

  logic                v0_r;
  mexp_pkg::residue_t  pow0_r, pow0_nxt;
  mexp_pkg::expo_t     exp0_r;
  logic [31:0]         b_ext;

  assign en       = !vld_c[SCAN] || out_ready;
  assign in_ready = en;

  // base < 2^31 < 3p: fold by zero, one or two primes
  assign b_ext = {1'b0, in_base_value};
  always_comb begin
    if (b_ext >= mexp_pkg::PRIME_X2) begin
      pow0_nxt = 30'(b_ext - mexp_pkg::PRIME_X2);
    end else if (b_ext >= mexp_pkg::PRIME_X1) begin
      pow0_nxt = 30'(b_ext - mexp_pkg::PRIME_X1);
    end else begin
      pow0_nxt = b_ext[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pow0_r <= pow0_nxt;
      exp0_r <= in_exponent_value & EXP_MASK;
    end
  end

  assign vld_c[0] = v0_r;
  assign acc_c[0] = 30'd1;
  assign pow_c[0] = pow0_r;
  assign exp_c[0] = exp0_r;

  for (genvar g = 0; g < SCAN; g++) begin : g_bit
    mexp_bit_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (vld_c[g]),
      .acc_in   (acc_c[g]),
      .pow_in   (pow_c[g]),
      .exp_in   (exp_c[g]),
      .valid_out(vld_c[g+1]),
      .acc_out  (acc_c[g+1]),
      .pow_out  (pow_c[g+1]),
      .exp_out  (exp_c[g+1])
    );
  end

  assign out_valid        = vld_c[SCAN];
  assign out_power_result = acc_c[SCAN];
endmodule
`default_nettype wire
